// File: rtl/surt_pkg.sv
package surt_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SINK_BIT = 8;

    localparam logic [1:0] MODE_REGISTER = 2'd0;
    localparam logic [1:0] MODE_REMOVE   = 2'd1;
    localparam logic [1:0] MODE_READ     = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_INDEX    = 2'd3;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] flags;
        logic [31:0] target;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REPLY,
        S_RD_WAIT,
        S_SEARCH,
        S_DECIDE,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR
    } t_state;

endpackage

// File: rtl/surt_ram.sv
module surt_ram #(
    parameter int WORDS = 16,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(WORDS)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(WORDS)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sorted_usage_registration_table.sv
// channel   | handshake          | word
// ----------+--------------------+-------------------------------------------------
// command   | start, busy        | i_mode i_usage_page i_usage i_flags i_target i_index
// result    | o_valid (1 cycle)  | o_status o_count o_position o_out_usage_page
//           |                    | o_out_usage o_out_flags o_out_target
//
// a command is taken when start is high and busy low; o_valid follows as a single pulse
// rejects and reads: the strobe comes from S_REPLY or S_RD_WAIT after the accepting edge
// register/remove: S_SEARCH scans k entries, then S_DECIDE; a shift runs the read and write states,
// m entries moved one at a time, each move a read and a write on the memory's two ports
// synchronous reset clears the entry count; the entry memory needs no clearing
// the receiver cannot stall, busy stays high until the strobe cycle
module sorted_usage_registration_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_usage_page,
    input  logic [15:0] i_usage,
    input  logic [31:0] i_flags,
    input  logic [31:0] i_target,
    input  logic [3:0]  i_index,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [4:0]  o_count,
    output logic [3:0]  o_position,
    output logic [15:0] o_out_usage_page,
    output logic [15:0] o_out_usage,
    output logic [31:0] o_out_flags,
    output logic [31:0] o_out_target
);

    localparam int IDX_W = surt_pkg::IDX_W;
    localparam int CNT_W = surt_pkg::CNT_W;

    surt_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_count, n_count;

    logic [1:0]       r_mode;
    logic [31:0]      r_key;
    logic [31:0]      r_flags;
    logic [31:0]      r_target;
    logic [CNT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_hit, n_hit;
    logic [1:0]       r_status, n_status;
    logic [3:0]       r_pos, n_pos;
    surt_pkg::t_entry r_res, n_res;

    logic             accept;
    logic             reject;
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    surt_pkg::t_entry ram_wdata, ram_rdata;
    logic [31:0]      slot_ext;
    logic [CNT_W-1:0] slot_inc, ptr_inc, ptr_dec;

    surt_ram #(
        .WORDS (surt_pkg::DEPTH),
        .WIDTH ($bits(surt_pkg::t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept   = start && (r_state == surt_pkg::S_IDLE);
    assign reject   = ((i_mode == surt_pkg::MODE_REGISTER) || (i_mode == surt_pkg::MODE_REMOVE))
                      && ((i_flags[surt_pkg::SINK_BIT] && (i_target == 32'd0))
                          || ((i_mode == surt_pkg::MODE_REMOVE) && (i_target != 32'd0)));
    assign slot_ext = 32'(r_slot);
    assign slot_inc = r_slot + CNT_W'(1);
    assign ptr_inc  = r_ptr + CNT_W'(1);
    assign ptr_dec  = r_ptr - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= surt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_key    <= {i_usage_page, i_usage};
            r_flags  <= i_flags;
            r_target <= i_target;
        end
        r_slot   <= n_slot;
        r_ptr    <= n_ptr;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_res    <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = 1'b0;
        n_count     = r_count;
        n_slot      = r_slot;
        n_ptr       = r_ptr;
        n_hit       = r_hit;
        n_status    = r_status;
        n_pos       = r_pos;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_slot[IDX_W-1:0];
        ram_wdata   = '{key: r_key, flags: r_flags, target: r_target};
        ram_re      = 1'b0;
        ram_raddr   = r_slot[IDX_W-1:0];

        case (r_state)
            surt_pkg::S_IDLE: begin
                if (start) begin
                    n_status = surt_pkg::ST_OK;
                    n_pos    = 4'd0;
                    n_res    = '0;
                    n_slot   = '0;
                    if (reject || (i_mode == surt_pkg::MODE_UNUSED)) begin
                        n_status = surt_pkg::ST_REJECTED;
                        n_state  = surt_pkg::S_REPLY;
                    end else if (i_mode == surt_pkg::MODE_READ) begin
                        n_pos = i_index;
                        if ((32'(i_index) >= 32'(r_count))
                            || (32'(i_index) >= surt_pkg::DEPTH)) begin
                            n_status = surt_pkg::ST_INDEX;
                            n_state  = surt_pkg::S_REPLY;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = IDX_W'(i_index);
                            n_state   = surt_pkg::S_RD_WAIT;
                        end
                    end else if (r_count == '0) begin
                        n_hit   = 1'b0;
                        n_state = surt_pkg::S_DECIDE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_state   = surt_pkg::S_SEARCH;
                    end
                end
            end
            surt_pkg::S_REPLY: begin
                n_out_valid = 1'b1;
                n_state     = surt_pkg::S_IDLE;
            end
            surt_pkg::S_RD_WAIT: begin
                n_res       = ram_rdata;
                n_out_valid = 1'b1;
                n_state     = surt_pkg::S_IDLE;
            end
            surt_pkg::S_SEARCH: begin
                if (ram_rdata.key < r_key) begin
                    n_slot = slot_inc;
                    if (slot_inc == r_count) begin
                        n_hit   = 1'b0;
                        n_state = surt_pkg::S_DECIDE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = slot_inc[IDX_W-1:0];
                    end
                end else begin
                    n_hit   = (ram_rdata.key == r_key);
                    n_state = surt_pkg::S_DECIDE;
                end
            end
            surt_pkg::S_DECIDE: begin
                n_pos = slot_ext[3:0];
                if (r_mode == surt_pkg::MODE_REGISTER) begin
                    if (r_hit) begin
                        ram_we      = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = surt_pkg::S_IDLE;
                    end else if (r_count == CNT_W'(surt_pkg::DEPTH)) begin
                        n_status    = surt_pkg::ST_FULL;
                        n_out_valid = 1'b1;
                        n_state     = surt_pkg::S_IDLE;
                    end else begin
                        n_ptr   = r_count;
                        n_state = surt_pkg::S_UP_RD;
                    end
                end else if (r_hit) begin
                    n_ptr   = r_slot;
                    n_state = surt_pkg::S_DN_RD;
                end else begin
                    n_out_valid = 1'b1;
                    n_state     = surt_pkg::S_IDLE;
                end
            end
            surt_pkg::S_UP_RD: begin
                if (r_ptr == r_slot) begin
                    ram_we      = 1'b1;
                    n_count     = r_count + CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_state     = surt_pkg::S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_dec[IDX_W-1:0];
                    n_state   = surt_pkg::S_UP_WR;
                end
            end
            surt_pkg::S_UP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[IDX_W-1:0];
                ram_wdata = ram_rdata;
                n_ptr     = ptr_dec;
                n_state   = surt_pkg::S_UP_RD;
            end
            surt_pkg::S_DN_RD: begin
                if (ptr_inc == r_count) begin
                    n_count     = r_count - CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_state     = surt_pkg::S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_inc[IDX_W-1:0];
                    n_state   = surt_pkg::S_DN_WR;
                end
            end
            surt_pkg::S_DN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[IDX_W-1:0];
                ram_wdata = ram_rdata;
                n_ptr     = ptr_inc;
                n_state   = surt_pkg::S_DN_RD;
            end
            default: begin
                n_state = surt_pkg::S_IDLE;
            end
        endcase
    end

    logic [31:0] count_ext;
    assign count_ext = 32'(r_count);

    assign busy             = (r_state != surt_pkg::S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_count          = count_ext[4:0];
    assign o_position       = r_pos;
    assign o_out_usage_page = r_res.key[31:16];
    assign o_out_usage      = r_res.key[15:0];
    assign o_out_flags      = r_res.flags;
    assign o_out_target     = r_res.target;

endmodule

// File: rtl/surt_checker.sv
module surt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [4:0]  o_count,
    input logic [15:0] o_out_usage_page,
    input logic [15:0] o_out_usage,
    input logic [31:0] o_out_flags,
    input logic [31:0] o_out_target
);

    // every accepted word raises busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_count) <= surt_pkg::DEPTH))
        else $error("count above table depth");

    // only a successful read carries entry data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != surt_pkg::ST_OK) |->
            (o_out_usage_page == 16'd0) && (o_out_usage == 16'd0)
            && (o_out_flags == 32'd0) && (o_out_target == 32'd0))
        else $error("entry data on a failed word");

endmodule

bind sorted_usage_registration_table surt_checker u_surt_checker (.*);

// File: tb/sorted_usage_registration_table_tb.sv
`timescale 1ns / 100ps

module sorted_usage_registration_table_tb;

    localparam int ITEMS_PER_PHASE = 650;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] page;
        logic [15:0] usage;
        logic [31:0] flags;
        logic [31:0] target;
        logic [3:0]  index;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  count;
        logic [3:0]  position;
        logic [15:0] page;
        logic [15:0] usage;
        logic [31:0] flags;
        logic [31:0] target;
    } t_reply;

    class usage_table_model;
        logic [31:0] keys [surt_pkg::DEPTH];
        logic [31:0] flag_words [surt_pkg::DEPTH];
        logic [31:0] targets [surt_pkg::DEPTH];
        int held = 0;
        t_reply awaited_replies [$];
        int errors = 0;

        function void note_command(t_cmd c);
            t_reply e;
            logic [31:0] key;
            int slot;
            bit hit;
            e = '0;
            key = {c.page, c.usage};
            case (c.mode)
                surt_pkg::MODE_REGISTER, surt_pkg::MODE_REMOVE: begin
                    if ((c.flags[surt_pkg::SINK_BIT] && c.target == 32'd0) ||
                        (c.mode == surt_pkg::MODE_REMOVE && c.target != 32'd0)) begin
                        e.status = surt_pkg::ST_REJECTED;
                    end else begin
                        slot = 0;
                        while (slot < held && keys[slot] < key)
                            slot++;
                        hit = (slot < held) && (keys[slot] == key);
                        e.position = 4'(slot);
                        if (c.mode == surt_pkg::MODE_REGISTER) begin
                            if (hit) begin
                                flag_words[slot] = c.flags;
                                targets[slot] = c.target;
                            end else if (held >= surt_pkg::DEPTH) begin
                                e.status = surt_pkg::ST_FULL;
                            end else begin
                                for (int i = held; i > slot; i--) begin
                                    keys[i] = keys[i - 1];
                                    flag_words[i] = flag_words[i - 1];
                                    targets[i] = targets[i - 1];
                                end
                                keys[slot] = key;
                                flag_words[slot] = c.flags;
                                targets[slot] = c.target;
                                held++;
                            end
                        end else if (hit) begin
                            for (int i = slot; i + 1 < held; i++) begin
                                keys[i] = keys[i + 1];
                                flag_words[i] = flag_words[i + 1];
                                targets[i] = targets[i + 1];
                            end
                            held--;
                        end
                    end
                end
                surt_pkg::MODE_READ: begin
                    e.position = c.index;
                    if (int'(c.index) >= held) begin
                        e.status = surt_pkg::ST_INDEX;
                    end else begin
                        e.page = keys[c.index][31:16];
                        e.usage = keys[c.index][15:0];
                        e.flags = flag_words[c.index];
                        e.target = targets[c.index];
                    end
                end
                default: begin
                    e.status = surt_pkg::ST_REJECTED;
                end
            endcase
            e.count = 5'(held);
            awaited_replies.push_back(e);
        endfunction

        function void check_reply(t_reply r);
            t_reply e;
            if (awaited_replies.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: reply with no command waiting", $time);
                return;
            end
            e = awaited_replies.pop_front();
            if (r.status !== e.status || r.count !== e.count || r.position !== e.position ||
                r.page !== e.page || r.usage !== e.usage || r.flags !== e.flags ||
                r.target !== e.target) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch", $time);
                    $display("  expected st %0d cnt %0d pos %0d page %h usage %h flags %h tgt %h",
                             e.status, e.count, e.position, e.page, e.usage, e.flags,
                             e.target);
                    $display("  actual   st %0d cnt %0d pos %0d page %h usage %h flags %h tgt %h",
                             r.status, r.count, r.position, r.page, r.usage, r.flags,
                             r.target);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [15:0] i_usage_page;
    logic [15:0] i_usage;
    logic [31:0] i_flags;
    logic [31:0] i_target;
    logic [3:0]  i_index;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [4:0]  o_count;
    logic [3:0]  o_position;
    logic [15:0] o_out_usage_page;
    logic [15:0] o_out_usage;
    logic [31:0] o_out_flags;
    logic [31:0] o_out_target;

    usage_table_model usage_model = new();
    logic [31:0] key_pool [24];
    int idle_pct = 0;

    sorted_usage_registration_table DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_usage_page     (i_usage_page),
        .i_usage          (i_usage),
        .i_flags          (i_flags),
        .i_target         (i_target),
        .i_index          (i_index),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_count          (o_count),
        .o_position       (o_position),
        .o_out_usage_page (o_out_usage_page),
        .o_out_usage      (o_out_usage),
        .o_out_flags      (o_out_flags),
        .o_out_target     (o_out_target)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            usage_model.check_reply(t_reply'({o_status, o_count, o_position, o_out_usage_page,
                                              o_out_usage, o_out_flags, o_out_target}));
    end

    function automatic t_cmd make_cmd(logic [1:0] mode, logic [15:0] page, logic [15:0] usage,
                                      logic [31:0] flags, logic [31:0] target,
                                      logic [3:0] index);
        t_cmd c;
        c.mode = mode;
        c.page = page;
        c.usage = usage;
        c.flags = flags;
        c.target = target;
        c.index = index;
        return c;
    endfunction

    function automatic t_cmd random_cmd(bit grow);
        t_cmd c;
        int pick;
        logic [31:0] key;
        pick = $urandom_range(99);
        if (pick < (grow ? 60 : 20))
            c.mode = surt_pkg::MODE_REGISTER;
        else if (pick < 80)
            c.mode = surt_pkg::MODE_REMOVE;
        else if (pick < 97)
            c.mode = surt_pkg::MODE_READ;
        else
            c.mode = surt_pkg::MODE_UNUSED;
        key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(23)];
        c.page = key[31:16];
        c.usage = key[15:0];
        c.flags = $urandom;
        if (c.mode == surt_pkg::MODE_REMOVE) begin
            if ($urandom_range(3) != 0)
                c.flags[surt_pkg::SINK_BIT] = 1'b0;
            c.target = ($urandom_range(9) == 0) ? $urandom : 32'd0;
        end else begin
            c.target = ($urandom_range(4) == 0) ? 32'd0 : $urandom;
        end
        c.index = 4'($urandom_range(15));
        return c;
    endfunction

    // optional gap, then present the word and hold it until taken
    task automatic issue(t_cmd c);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_mode <= c.mode;
        i_usage_page <= c.page;
        i_usage <= c.usage;
        i_flags <= c.flags;
        i_target <= c.target;
        i_index <= c.index;
        do @(posedge i_clk); while (busy !== 1'b0);
        usage_model.note_command(c);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = surt_pkg::MODE_REGISTER;
        i_usage_page = '0;
        i_usage = '0;
        i_flags = '0;
        i_target = '0;
        i_index = '0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h0000_FFFF;
        key_pool[3] = 32'hFFFF_0000;
        for (int k = 4; k < 24; k++)
            key_pool[k] = $urandom;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, rejects, extremes, fill to full
        idle_pct = 9;
        issue(make_cmd(surt_pkg::MODE_READ, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd0));
        issue(make_cmd(surt_pkg::MODE_REMOVE, 16'h1234, 16'h5678, 32'd0, 32'd0, 4'd0));
        issue(make_cmd(surt_pkg::MODE_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0,
                       4'd15));
        issue(make_cmd(surt_pkg::MODE_REGISTER, 16'h0001, 16'h0002, 32'h0000_0100, 32'd0,
                       4'd0));
        issue(make_cmd(surt_pkg::MODE_REMOVE, 16'h0001, 16'h0002, 32'h0000_0100, 32'd0,
                       4'd0));
        issue(make_cmd(surt_pkg::MODE_REMOVE, 16'h0001, 16'h0002, 32'd0, 32'h0000_0001,
                       4'd0));
        issue(make_cmd(surt_pkg::MODE_REGISTER, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 4'd0));
        issue(make_cmd(surt_pkg::MODE_REGISTER, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd0));
        issue(make_cmd(surt_pkg::MODE_REGISTER, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 32'd1,
                       4'd0));
        for (int k = 0; k < 14; k++)
            issue(make_cmd(surt_pkg::MODE_REGISTER, 16'h7000 - 16'(k * 256), 16'(k),
                           32'(k) << 12, 32'h1000_0000 + 32'(k), 4'd0));
        issue(make_cmd(surt_pkg::MODE_REGISTER, 16'h8000, 16'h0001, 32'h5555_5555, 32'd7,
                       4'd0));
        issue(make_cmd(surt_pkg::MODE_REGISTER, 16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA, 32'd2,
                       4'd0));
        issue(make_cmd(surt_pkg::MODE_READ, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd15));
        issue(make_cmd(surt_pkg::MODE_REMOVE, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd0));
        issue(make_cmd(surt_pkg::MODE_READ, 16'h0000, 16'h0000, 32'd0, 32'd0, 4'd15));

        // random: each phase alternates runs of 40 words that favour registering with runs that favour removing
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 9 : (phase == 1) ? 55 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                issue(random_cmd(((n / 40) % 2) == 0));
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (usage_model.awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (usage_model.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
